// ===== hdl/qs_pkg.sv =====
// shared constants and types for the quicksort sorter
package qs_pkg;

    localparam int VALUE_W     = 32;
    localparam int MAX_ITEMS   = 64;
    localparam int STORE_DEPTH = 64;
    localparam int STACK_DEPTH = 64;
    localparam int IDX_W       = $clog2(STORE_DEPTH);
    localparam int CNT_W       = IDX_W + 1;
    localparam int SP_W        = $clog2(STACK_DEPTH) + 1;
    localparam int RANGE_W     = 2 * IDX_W;
    // scan indices run one past either end of a range
    localparam int SCAN_W      = IDX_W + 2;

    typedef enum logic [3:0] {
        S_LOAD,
        S_INIT,
        S_POP,
        S_RANGE,
        S_PIVOT,
        S_IRD,
        S_ICHK,
        S_JRD,
        S_JCHK,
        S_SWAP_A,
        S_SWAP_B,
        S_PUSH_L,
        S_PUSH_R,
        S_OUT_RD,
        S_OUT_SHOW
    } t_state;

    typedef enum logic [1:0] {
        WSEL_IN,
        WSEL_VI,
        WSEL_VJ
    } t_wsel;

    typedef struct packed {
        logic             we;
        logic [IDX_W-1:0] waddr;
        t_wsel            wsel;
        logic             re;
        logic [IDX_W-1:0] raddr;
        logic             cap_pivot;
        logic             cap_vi;
        logic             cap_vj;
    } t_store_ctrl;

    typedef struct packed {
        logic lt;
        logic gt;
    } t_cmp_stat;

endpackage

// ===== hdl/qs_store.sv =====
// value store with the shared pivot comparator and swap holding registers
module qs_store (
    input  logic                                i_clk,
    input  qs_pkg::t_store_ctrl                 i_ctrl,
    input  logic signed [qs_pkg::VALUE_W-1:0]   i_sample_value,
    output logic signed [qs_pkg::VALUE_W-1:0]   o_rd_value,
    output qs_pkg::t_cmp_stat                   o_cmp
);

    logic signed [qs_pkg::VALUE_W-1:0] r_mem [qs_pkg::STORE_DEPTH];
    logic signed [qs_pkg::VALUE_W-1:0] r_rdata;
    logic signed [qs_pkg::VALUE_W-1:0] r_pivot;
    logic signed [qs_pkg::VALUE_W-1:0] r_vi;
    logic signed [qs_pkg::VALUE_W-1:0] r_vj;
    logic signed [qs_pkg::VALUE_W-1:0] w_wdata;

    // write data select: new sample or one side of a swap
    always_comb begin
        unique case (i_ctrl.wsel)
            qs_pkg::WSEL_IN: w_wdata = i_sample_value;
            qs_pkg::WSEL_VI: w_wdata = r_vi;
            qs_pkg::WSEL_VJ: w_wdata = r_vj;
            default:         w_wdata = i_sample_value;
        endcase
    end

    // single write port, single registered read port
    always_ff @(posedge i_clk) begin
        if (i_ctrl.we) begin
            r_mem[i_ctrl.waddr] <= w_wdata;
        end
        if (i_ctrl.re) begin
            r_rdata <= r_mem[i_ctrl.raddr];
        end
    end

    // pivot and swap operands taken from the read register
    always_ff @(posedge i_clk) begin
        if (i_ctrl.cap_pivot) begin
            r_pivot <= r_rdata;
        end
        if (i_ctrl.cap_vi) begin
            r_vi <= r_rdata;
        end
        if (i_ctrl.cap_vj) begin
            r_vj <= r_rdata;
        end
    end

    // shared signed compare against the pivot
    assign o_cmp.lt   = r_rdata < r_pivot;
    assign o_cmp.gt   = r_rdata > r_pivot;
    assign o_rd_value = r_rdata;

endmodule

// ===== hdl/qs_seq.sv =====
// sequencer: load counting, range stack, partition scan and output burst
module qs_seq (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    input  logic                i_is_last,
    input  logic                i_stall,
    input  qs_pkg::t_cmp_stat   i_cmp,
    output logic                o_stall,
    output logic                o_valid,
    output logic                o_end_of_run,
    output logic                o_dropped_flag,
    output qs_pkg::t_store_ctrl o_ctrl
);

    qs_pkg::t_state                r_state;
    qs_pkg::t_state                n_state;
    logic [qs_pkg::CNT_W-1:0]      r_count;
    logic                          r_overflow;
    logic [qs_pkg::SP_W-1:0]       r_sp;
    logic [qs_pkg::IDX_W-1:0]      r_lo;
    logic [qs_pkg::IDX_W-1:0]      r_hi;
    logic [qs_pkg::SCAN_W-1:0]     r_i;
    logic [qs_pkg::SCAN_W-1:0]     r_j;
    logic [qs_pkg::IDX_W-1:0]      r_k;
    logic [qs_pkg::RANGE_W-1:0]    r_stack_mem [qs_pkg::STACK_DEPTH];
    logic [qs_pkg::RANGE_W-1:0]    r_stack_rd;

    logic                          w_accept;
    logic                          w_room;
    logic                          w_stack_room;
    logic                          w_multi;
    logic                          w_i_lt_hi;
    logic                          w_j_gt_lo;
    logic                          w_i_le_j;
    logic [qs_pkg::SCAN_W-1:0]     w_i_inc;
    logic [qs_pkg::SCAN_W-1:0]     w_j_dec;
    logic                          w_next_le;
    logic                          w_push_l;
    logic                          w_push_r;
    logic                          w_last_out;
    logic [qs_pkg::IDX_W-1:0]      w_top_lo;
    logic [qs_pkg::IDX_W-1:0]      w_top_hi;
    logic [qs_pkg::IDX_W:0]        w_mid_sum;
    logic [qs_pkg::SP_W-1:0]       w_sp_dec;
    logic                          w_stk_we;
    logic [qs_pkg::RANGE_W-1:0]    w_stk_wdata;
    logic                          w_stk_re;

    // index compares and steps
    assign w_accept     = i_valid && (r_state == qs_pkg::S_LOAD);
    assign w_room       = r_count < qs_pkg::CNT_W'(qs_pkg::MAX_ITEMS);
    assign w_stack_room = r_sp < qs_pkg::SP_W'(qs_pkg::STACK_DEPTH);
    assign w_multi      = r_count >= qs_pkg::CNT_W'(2);
    assign w_i_lt_hi    = $signed(r_i) < $signed({2'b00, r_hi});
    assign w_j_gt_lo    = $signed(r_j) > $signed({2'b00, r_lo});
    assign w_i_le_j     = $signed(r_i) <= $signed(r_j);
    assign w_i_inc      = r_i + qs_pkg::SCAN_W'(1);
    assign w_j_dec      = r_j - qs_pkg::SCAN_W'(1);
    assign w_next_le    = $signed(w_i_inc) <= $signed(w_j_dec);
    assign w_push_l     = w_j_gt_lo && w_stack_room;
    assign w_push_r     = w_i_lt_hi && w_stack_room;
    assign w_last_out   = {1'b0, r_k} == (r_count - qs_pkg::CNT_W'(1));
    assign w_sp_dec     = r_sp - qs_pkg::SP_W'(1);

    // popped range and its middle element
    assign w_top_lo  = r_stack_rd[qs_pkg::RANGE_W-1:qs_pkg::IDX_W];
    assign w_top_hi  = r_stack_rd[qs_pkg::IDX_W-1:0];
    assign w_mid_sum = {1'b0, w_top_lo} + {1'b0, w_top_hi};

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            qs_pkg::S_LOAD: begin
                if (w_accept && i_is_last) begin
                    n_state = qs_pkg::S_INIT;
                end
            end
            qs_pkg::S_INIT: begin
                n_state = w_multi ? qs_pkg::S_POP : qs_pkg::S_OUT_RD;
            end
            qs_pkg::S_POP: begin
                n_state = (r_sp == '0) ? qs_pkg::S_OUT_RD : qs_pkg::S_RANGE;
            end
            qs_pkg::S_RANGE:  n_state = qs_pkg::S_PIVOT;
            qs_pkg::S_PIVOT:  n_state = qs_pkg::S_IRD;
            qs_pkg::S_IRD:    n_state = qs_pkg::S_ICHK;
            qs_pkg::S_ICHK: begin
                n_state = (i_cmp.lt && w_i_lt_hi) ? qs_pkg::S_IRD : qs_pkg::S_JRD;
            end
            qs_pkg::S_JRD:    n_state = qs_pkg::S_JCHK;
            qs_pkg::S_JCHK: begin
                priority if (i_cmp.gt && w_j_gt_lo) begin
                    n_state = qs_pkg::S_JRD;
                end else if (w_i_le_j) begin
                    n_state = qs_pkg::S_SWAP_A;
                end else begin
                    n_state = qs_pkg::S_PUSH_L;
                end
            end
            qs_pkg::S_SWAP_A: n_state = qs_pkg::S_SWAP_B;
            qs_pkg::S_SWAP_B: begin
                n_state = w_next_le ? qs_pkg::S_IRD : qs_pkg::S_PUSH_L;
            end
            qs_pkg::S_PUSH_L: n_state = qs_pkg::S_PUSH_R;
            qs_pkg::S_PUSH_R: n_state = qs_pkg::S_POP;
            qs_pkg::S_OUT_RD: n_state = qs_pkg::S_OUT_SHOW;
            qs_pkg::S_OUT_SHOW: begin
                if (!i_stall) begin
                    n_state = w_last_out ? qs_pkg::S_LOAD : qs_pkg::S_OUT_RD;
                end
            end
            default: n_state = qs_pkg::S_LOAD;
        endcase
    end

    // control outputs for the store, the stack and the ports
    always_comb begin
        o_ctrl           = '0;
        o_ctrl.wsel      = qs_pkg::WSEL_IN;
        w_stk_we         = 1'b0;
        w_stk_wdata      = {r_i[qs_pkg::IDX_W-1:0], r_hi};
        w_stk_re         = 1'b0;
        unique case (r_state)
            qs_pkg::S_LOAD: begin
                o_ctrl.we    = w_accept && w_room;
                o_ctrl.waddr = r_count[qs_pkg::IDX_W-1:0];
            end
            qs_pkg::S_INIT: begin
                w_stk_we    = w_multi;
                w_stk_wdata = {qs_pkg::IDX_W'(0),
                               w_sp_dec[0] ? r_count[qs_pkg::IDX_W-1:0] - qs_pkg::IDX_W'(1)
                                           : r_count[qs_pkg::IDX_W-1:0] - qs_pkg::IDX_W'(1)};
            end
            qs_pkg::S_POP: begin
                w_stk_re = r_sp != '0;
            end
            qs_pkg::S_RANGE: begin
                o_ctrl.re    = 1'b1;
                o_ctrl.raddr = w_mid_sum[qs_pkg::IDX_W:1];
            end
            qs_pkg::S_PIVOT: begin
                o_ctrl.cap_pivot = 1'b1;
            end
            qs_pkg::S_IRD: begin
                o_ctrl.re    = 1'b1;
                o_ctrl.raddr = r_i[qs_pkg::IDX_W-1:0];
            end
            qs_pkg::S_ICHK: begin
                o_ctrl.cap_vi = 1'b1;
            end
            qs_pkg::S_JRD: begin
                o_ctrl.re    = 1'b1;
                o_ctrl.raddr = r_j[qs_pkg::IDX_W-1:0];
            end
            qs_pkg::S_JCHK: begin
                o_ctrl.cap_vj = 1'b1;
            end
            qs_pkg::S_SWAP_A: begin
                o_ctrl.we    = 1'b1;
                o_ctrl.waddr = r_i[qs_pkg::IDX_W-1:0];
                o_ctrl.wsel  = qs_pkg::WSEL_VJ;
            end
            qs_pkg::S_SWAP_B: begin
                o_ctrl.we    = 1'b1;
                o_ctrl.waddr = r_j[qs_pkg::IDX_W-1:0];
                o_ctrl.wsel  = qs_pkg::WSEL_VI;
            end
            qs_pkg::S_PUSH_L: begin
                w_stk_we    = w_push_l;
                w_stk_wdata = {r_lo, r_j[qs_pkg::IDX_W-1:0]};
            end
            qs_pkg::S_PUSH_R: begin
                w_stk_we    = w_push_r;
                w_stk_wdata = {r_i[qs_pkg::IDX_W-1:0], r_hi};
            end
            qs_pkg::S_OUT_RD: begin
                o_ctrl.re    = 1'b1;
                o_ctrl.raddr = r_k;
            end
            qs_pkg::S_OUT_SHOW: begin
                o_ctrl.re = 1'b0;
            end
            default: begin
                o_ctrl.re = 1'b0;
            end
        endcase
    end

    assign o_stall        = r_state != qs_pkg::S_LOAD;
    assign o_valid        = r_state == qs_pkg::S_OUT_SHOW;
    assign o_end_of_run   = w_last_out;
    assign o_dropped_flag = r_overflow;

    // control state: item count, overflow, stack pointer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= qs_pkg::S_LOAD;
            r_count    <= '0;
            r_overflow <= 1'b0;
            r_sp       <= '0;
        end else begin
            r_state <= n_state;
            unique case (r_state)
                qs_pkg::S_LOAD: begin
                    if (w_accept) begin
                        if (w_room) begin
                            r_count <= r_count + qs_pkg::CNT_W'(1);
                        end else begin
                            r_overflow <= 1'b1;
                        end
                    end
                end
                qs_pkg::S_INIT: begin
                    if (w_multi) begin
                        r_sp <= qs_pkg::SP_W'(1);
                    end
                end
                qs_pkg::S_POP: begin
                    if (r_sp != '0) begin
                        r_sp <= w_sp_dec;
                    end
                end
                qs_pkg::S_PUSH_L: begin
                    if (w_push_l) begin
                        r_sp <= r_sp + qs_pkg::SP_W'(1);
                    end
                end
                qs_pkg::S_PUSH_R: begin
                    if (w_push_r) begin
                        r_sp <= r_sp + qs_pkg::SP_W'(1);
                    end
                end
                qs_pkg::S_OUT_SHOW: begin
                    if (!i_stall && w_last_out) begin
                        r_count    <= '0;
                        r_overflow <= 1'b0;
                        r_sp       <= '0;
                    end
                end
                default: begin
                    r_sp <= r_sp;
                end
            endcase
        end
    end

    // range bounds, scan indices and output index
    always_ff @(posedge i_clk) begin
        unique case (r_state)
            qs_pkg::S_INIT: begin
                r_k <= '0;
            end
            qs_pkg::S_RANGE: begin
                r_lo <= w_top_lo;
                r_hi <= w_top_hi;
                r_i  <= {2'b00, w_top_lo};
                r_j  <= {2'b00, w_top_hi};
            end
            qs_pkg::S_ICHK: begin
                if (i_cmp.lt && w_i_lt_hi) begin
                    r_i <= w_i_inc;
                end
            end
            qs_pkg::S_JCHK: begin
                if (i_cmp.gt && w_j_gt_lo) begin
                    r_j <= w_j_dec;
                end
            end
            qs_pkg::S_SWAP_B: begin
                r_i <= w_i_inc;
                r_j <= w_j_dec;
            end
            qs_pkg::S_OUT_SHOW: begin
                if (!i_stall && !w_last_out) begin
                    r_k <= r_k + qs_pkg::IDX_W'(1);
                end
            end
            default: begin
                r_k <= r_k;
            end
        endcase
    end

    // range stack memory, registered read
    always_ff @(posedge i_clk) begin
        if (w_stk_we) begin
            r_stack_mem[r_sp[qs_pkg::SP_W-2:0]] <= w_stk_wdata;
        end
        if (w_stk_re) begin
            r_stack_rd <= r_stack_mem[w_sp_dec[qs_pkg::SP_W-2:0]];
        end
    end

endmodule

// ===== hdl/quicksort_sorter.sv =====
// top level of the quicksort sorter
//
// Input channel: i_valid / o_stall carry one signed value per beat, with
// i_is_last marking the final value of a set. A value is accepted on every
// beat while loading; up to 64 values are kept, later ones are dropped and
// reported. After the last beat o_stall stays high while the set is sorted
// in place (Hoare partition around the middle element, pending ranges on a
// 64-entry stack). Each compare step is one access to the value store's
// single read port plus a compare in the shared comparator.
// Output channel: o_valid / i_stall give one sorted value per beat, each
// read from the store before it is shown; o_end_of_run marks the last one
// and o_dropped_flag is high on every beat of a set that lost values. A
// stall simply holds the current beat. After the last output beat the block
// returns to loading. Reset (synchronous, active low) empties the set;
// there is no clearing pass.
module quicksort_sorter (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_valid,
    output logic                                o_stall,
    input  logic signed [qs_pkg::VALUE_W-1:0]   i_sample_value,
    input  logic                                i_is_last,
    output logic                                o_valid,
    input  logic                                i_stall,
    output logic signed [qs_pkg::VALUE_W-1:0]   o_sorted_value,
    output logic                                o_end_of_run,
    output logic                                o_dropped_flag
);

    qs_pkg::t_store_ctrl w_ctrl;
    qs_pkg::t_cmp_stat   w_cmp;

    // sequencer
    qs_seq u_seq (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .i_is_last      (i_is_last),
        .i_stall        (i_stall),
        .i_cmp          (w_cmp),
        .o_stall        (o_stall),
        .o_valid        (o_valid),
        .o_end_of_run   (o_end_of_run),
        .o_dropped_flag (o_dropped_flag),
        .o_ctrl         (w_ctrl)
    );

    // value store and comparator
    qs_store u_store (
        .i_clk          (i_clk),
        .i_ctrl         (w_ctrl),
        .i_sample_value (i_sample_value),
        .o_rd_value     (o_sorted_value),
        .o_cmp          (w_cmp)
    );

endmodule
